// File: rtl/core/aabb_xf_pkg.sv
// shared constants and types for the bounding box affine transform
`default_nettype none

package aabb_xf_pkg;

    // field and coefficient widths fixed by the interface
    localparam int FIELD_W   = 32;
    localparam int COEF_W    = 32;
    localparam int NUM_AXES  = 3;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_LO = 3'd0,
        REG_ROW0_HI = 3'd1,
        REG_ROW1_LO = 3'd2,
        REG_ROW1_HI = 3'd3,
        REG_ROW2_LO = 3'd4,
        REG_ROW2_HI = 3'd5
    } reg_idx_t;

    // reset matrix is the identity
    localparam logic [CFG_W-1:0] ROW0_LO_RST = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] ROW0_HI_RST = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW1_LO_RST = 64'h0001_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW1_HI_RST = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW2_LO_RST = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW2_HI_RST = 64'h0000_0000_0001_0000;

endpackage

`default_nettype wire

// File: rtl/core/aabb_affine_transform.sv
// pipelined affine transform of a 3d axis-aligned bounding box
`default_nettype none

// Takes one box per request on the s_ stream and returns the transformed box on the
// m_ stream, one result per box, in order. Throughput is one box per clock while m_tready
// is high. There are four register stages (order/select, multiply, sum, round/saturate),
// and m_tvalid is driven by the valid bit of the last of them, v4_reg.
// Because min and max of an affine map over the eight corners
// separate per matrix term, each output axis uses a min and a max dot product,
// choosing lo or hi of each input axis by the sign of its coefficient: 18 signed
// 32 x COORD_WIDTH multipliers in the multiply stage set the area. Each stage
// holds its own valid bit, so bubbles are squeezed out under back-pressure.
// Results round to nearest (ties up), saturate to COORD_WIDTH bits with the
// overflow flag in m_tuser; an all-zero box gives a zero box. The matrix may be
// written only while the pipeline is empty; cfg_ready is always high.
module aabb_affine_transform
    import aabb_xf_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z (32 bits each)
    input  wire logic [6*FIELD_W-1:0] s_tdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z (32 bits each)
    output logic [6*FIELD_W-1:0]      m_tdata,
    // overflow
    output logic                      m_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int PW   = COEF_W + CW;
    localparam int TW   = COEF_W + FRAC_BITS;
    localparam int SW   = ((PW > TW) ? PW : TW) + 3;
    localparam int HSH  = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
    localparam logic [SW-1:0] HALF = (FRAC_BITS > 0) ? (SW'(1) << HSH) : '0;
    localparam logic signed [SW-1:0] HI_LIM = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] LO_LIM = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    // configuration registers
    logic [CFG_W-1:0] cfg_reg [NUM_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_ROW0_LO] <= ROW0_LO_RST;
            cfg_reg[REG_ROW0_HI] <= ROW0_HI_RST;
            cfg_reg[REG_ROW1_LO] <= ROW1_LO_RST;
            cfg_reg[REG_ROW1_HI] <= ROW1_HI_RST;
            cfg_reg[REG_ROW2_LO] <= ROW2_LO_RST;
            cfg_reg[REG_ROW2_HI] <= ROW2_HI_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROW0_LO: cfg_reg[REG_ROW0_LO] <= cfg_data;
                REG_ROW0_HI: cfg_reg[REG_ROW0_HI] <= cfg_data;
                REG_ROW1_LO: cfg_reg[REG_ROW1_LO] <= cfg_data;
                REG_ROW1_HI: cfg_reg[REG_ROW1_HI] <= cfg_data;
                REG_ROW2_LO: cfg_reg[REG_ROW2_LO] <= cfg_data;
                REG_ROW2_HI: cfg_reg[REG_ROW2_HI] <= cfg_data;
                default: ;
            endcase
        end
    end

    // matrix coefficients and translations unpacked
    logic signed [COEF_W-1:0] coef [NUM_AXES][NUM_AXES];
    logic signed [COEF_W-1:0] trans [NUM_AXES];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            coef[a][0] = cfg_reg[2*a][COEF_W-1:0];
            coef[a][1] = cfg_reg[2*a][CFG_W-1:COEF_W];
            coef[a][2] = cfg_reg[2*a+1][COEF_W-1:0];
            trans[a]   = cfg_reg[2*a+1][CFG_W-1:COEF_W];
        end
    end

    // per-stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage 1: order each axis, detect null box, pick operands by coefficient sign
    logic signed [CW-1:0] lo_ax [NUM_AXES];
    logic signed [CW-1:0] hi_ax [NUM_AXES];
    logic signed [CW-1:0] opmin_next [NUM_AXES][NUM_AXES];
    logic signed [CW-1:0] opmax_next [NUM_AXES][NUM_AXES];
    logic signed [CW-1:0] opmin_reg  [NUM_AXES][NUM_AXES];
    logic signed [CW-1:0] opmax_reg  [NUM_AXES][NUM_AXES];
    logic                 null_next, null1_reg, null2_reg, null3_reg;

    always_comb begin
        logic signed [CW-1:0] u;
        logic signed [CW-1:0] w;
        null_next = 1'b1;
        for (int j = 0; j < NUM_AXES; j++) begin
            u = s_tdata[j*FIELD_W +: CW];
            w = s_tdata[(j+3)*FIELD_W +: CW];
            if (u != '0 || w != '0) null_next = 1'b0;
            lo_ax[j] = (u > w) ? w : u;
            hi_ax[j] = (u > w) ? u : w;
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                opmin_next[a][j] = coef[a][j][COEF_W-1] ? hi_ax[j] : lo_ax[j];
                opmax_next[a][j] = coef[a][j][COEF_W-1] ? lo_ax[j] : hi_ax[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            opmin_reg <= opmin_next;
            opmax_reg <= opmax_next;
            null1_reg <= null_next;
        end
    end

    // stage 2: products, translation term with rounding half folded in
    logic signed [PW-1:0] pmin_next [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0] pmax_next [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0] pmin_reg  [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0] pmax_reg  [NUM_AXES][NUM_AXES];
    logic signed [SW-1:0] toff_next [NUM_AXES];
    logic signed [SW-1:0] toff_reg  [NUM_AXES];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                pmin_next[a][j] = PW'(coef[a][j]) * PW'(opmin_reg[a][j]);
                pmax_next[a][j] = PW'(coef[a][j]) * PW'(opmax_reg[a][j]);
            end
            toff_next[a] = (SW'(trans[a]) <<< FRAC_BITS) + signed'(HALF);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            pmin_reg  <= pmin_next;
            pmax_reg  <= pmax_next;
            toff_reg  <= toff_next;
            null2_reg <= null1_reg;
        end
    end

    // stage 3: exact sums for the extreme corners
    logic signed [SW-1:0] smin_next [NUM_AXES];
    logic signed [SW-1:0] smax_next [NUM_AXES];
    logic signed [SW-1:0] smin_reg  [NUM_AXES];
    logic signed [SW-1:0] smax_reg  [NUM_AXES];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            smin_next[a] = SW'(pmin_reg[a][0]) + SW'(pmin_reg[a][1])
                         + SW'(pmin_reg[a][2]) + toff_reg[a];
            smax_next[a] = SW'(pmax_reg[a][0]) + SW'(pmax_reg[a][1])
                         + SW'(pmax_reg[a][2]) + toff_reg[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            smin_reg  <= smin_next;
            smax_reg  <= smax_next;
            null3_reg <= null2_reg;
        end
    end

    // stage 4: round, saturate, null box override
    logic [6*FIELD_W-1:0] data_next, data_reg;
    logic                 ovf_next, ovf_reg;

    always_comb begin
        logic signed [SW-1:0] rmin;
        logic signed [SW-1:0] rmax;
        logic signed [CW-1:0] cmin;
        logic signed [CW-1:0] cmax;
        ovf_next  = 1'b0;
        data_next = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            rmin = smin_reg[a] >>> FRAC_BITS;
            rmax = smax_reg[a] >>> FRAC_BITS;
            cmin = rmin[CW-1:0];
            cmax = rmax[CW-1:0];
            if (rmin < LO_LIM) begin
                cmin     = LO_LIM[CW-1:0];
                ovf_next = 1'b1;
            end
            if (rmin > HI_LIM) begin
                cmin     = HI_LIM[CW-1:0];
                ovf_next = 1'b1;
            end
            if (rmax < LO_LIM) begin
                cmax     = LO_LIM[CW-1:0];
                ovf_next = 1'b1;
            end
            if (rmax > HI_LIM) begin
                cmax     = HI_LIM[CW-1:0];
                ovf_next = 1'b1;
            end
            data_next[a*FIELD_W +: FIELD_W]     = FIELD_W'(cmin);
            data_next[(a+3)*FIELD_W +: FIELD_W] = FIELD_W'(cmax);
        end
        if (null3_reg) begin
            data_next = '0;
            ovf_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            data_reg <= data_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign m_tdata  = data_reg;
    assign m_tuser  = ovf_reg;
    assign m_tvalid = v4_reg;

`ifndef SYNTHESIS
    // transformed box is never inverted
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[31:0]) <= $signed(m_tdata[127:96]))
                  && ($signed(m_tdata[63:32]) <= $signed(m_tdata[159:128]))
                  && ($signed(m_tdata[95:64]) <= $signed(m_tdata[191:160])))
        else $error("output box has min above max");

    // input only blocked when every stage holds a request
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with a bubble in the pipeline");

    // a saturated result never comes from an all-zero box
    a_ovf_box: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata != '0))
        else $error("overflow flagged on a zero box");

    // pipeline empty right after reset
    a_rst_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
